// ===== rtl/core/ccr_pkg.sv =====
package ccr_pkg;

    // Scanner modes
    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_SLASH  = 3'd1;
    localparam logic [2:0] MODE_LINE   = 3'd2;
    localparam logic [2:0] MODE_BLOCK  = 3'd3;
    localparam logic [2:0] MODE_STAR   = 3'd4;

    // Characters of interest
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       stream_end;
        logic       last;
    } t_result;

    // Results of one scanned beat: zero, one or two entries
    typedef struct packed {
        logic [1:0] count;
        t_result    res_a;
        t_result    res_b;
    } t_scan_out;

endpackage

// ===== rtl/core/ccr_scan.sv =====
module ccr_scan
    import ccr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic       i_cmd,
    input  logic [7:0] i_in_char,
    output t_scan_out  o_scan
);

    logic [2:0] r_mode;
    logic [2:0] n_mode;

    function automatic t_result mk_res(logic [7:0] ch, logic vld, logic fin, logic lst);
        t_result r;
        r.out_char   = ch;
        r.char_valid = vld;
        r.stream_end = fin;
        r.last       = lst;
        return r;
    endfunction

    always_comb begin
        o_scan.count = 2'd0;
        o_scan.res_a = mk_res(8'h00, 1'b0, 1'b0, 1'b0);
        o_scan.res_b = mk_res(8'h00, 1'b0, 1'b0, 1'b0);
        n_mode       = r_mode;
        if (i_cmd) begin
            // flush a held slash, then close the stream
            if (r_mode == MODE_SLASH) begin
                o_scan.count = 2'd2;
                o_scan.res_a = mk_res(CH_SLASH, 1'b1, 1'b0, 1'b0);
                o_scan.res_b = mk_res(8'h00, 1'b0, 1'b1, 1'b1);
            end else begin
                o_scan.count = 2'd1;
                o_scan.res_a = mk_res(8'h00, 1'b0, 1'b1, 1'b1);
            end
            n_mode = MODE_NORMAL;
        end else begin
            unique case (r_mode)
                MODE_SLASH: begin
                    if (i_in_char == CH_SLASH || i_in_char == CH_STAR) begin
                        o_scan.count = 2'd1;
                        o_scan.res_a = mk_res(CH_SPACE, 1'b1, 1'b0, 1'b1);
                        n_mode = (i_in_char == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
                    end else begin
                        o_scan.count = 2'd2;
                        o_scan.res_a = mk_res(CH_SLASH, 1'b1, 1'b0, 1'b0);
                        o_scan.res_b = mk_res(i_in_char, 1'b1, 1'b0, 1'b1);
                        n_mode = MODE_NORMAL;
                    end
                end
                MODE_LINE: begin
                    if (i_in_char == CH_NEWLINE) begin
                        o_scan.count = 2'd1;
                        o_scan.res_a = mk_res(i_in_char, 1'b1, 1'b0, 1'b1);
                        n_mode = MODE_NORMAL;
                    end
                end
                MODE_BLOCK: begin
                    if (i_in_char == CH_STAR) begin
                        n_mode = MODE_STAR;
                    end
                end
                MODE_STAR: begin
                    if (i_in_char == CH_SLASH) begin
                        n_mode = MODE_NORMAL;
                    end else if (i_in_char != CH_STAR) begin
                        n_mode = MODE_BLOCK;
                    end
                end
                default: begin
                    if (i_in_char == CH_SLASH) begin
                        n_mode = MODE_SLASH;
                    end else begin
                        o_scan.count = 2'd1;
                        o_scan.res_a = mk_res(i_in_char, 1'b1, 1'b0, 1'b1);
                        n_mode = MODE_NORMAL;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
        end else if (i_adv) begin
            r_mode <= n_mode;
        end
    end

`ifndef SYNTHESIS
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_cmd) |=> (r_mode == MODE_NORMAL))
        else $error("mode not cleared after end of stream");
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_scan.count == 2'd1) |-> o_scan.res_a.last)
        else $error("single result lacks last");
    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_scan.count == 2'd2) |-> (!o_scan.res_a.last && o_scan.res_b.last))
        else $error("result pair has wrong last marking");
`endif

endmodule

// ===== rtl/core/ccr_out_queue.sv =====
module ccr_out_queue
    import ccr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_scan_out i_scan,
    input  logic      i_stall,
    output logic      o_room,
    output logic      o_valid,
    output t_result   o_res
);

    logic [1:0] r_cnt;
    t_result    r_slot0;
    t_result    r_slot1;
    logic       take;

    assign o_valid = (r_cnt != 2'd0);
    assign o_res   = r_slot0;
    assign take    = o_valid && !i_stall;
    // room only when the queue is empty or drains empty this cycle
    assign o_room  = (r_cnt == 2'd0) || (r_cnt == 2'd1 && take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_push) begin
            r_cnt <= i_scan.count;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot0 <= i_scan.res_a;
            r_slot1 <= i_scan.res_b;
        end else if (take) begin
            r_slot0 <= r_slot1;
        end
    end

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_room)
        else $error("push into occupied queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count out of range");
    a_pair_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && i_scan.count == 2'd2) |=> (r_cnt == 2'd2))
        else $error("result pair not stored");
`endif

endmodule

// ===== rtl/core/c_comment_replacer.sv =====
// Channel  | valid    | stall    | payload
// ---------+----------+----------+-----------------------------------------------
// input    | i_valid  | o_stall  | i_cmd, i_in_char
// output   | o_valid  | i_stall  | o_out_char, o_char_valid, o_stream_end, o_last
//
// One input beat per cycle while o_stall is low. A beat is held in the input register, is
// scanned there and drops 0, 1 or 2 result beats into a two-slot output queue.
// Beats that give two results (a released or flushed slash) occupy the output port
// for both results, so the next beat that yields results waits behind them.
// Reset is synchronous, active low; it returns the scanner to plain text.
// o_stall follows i_stall combinationally through the queue room check.
module c_comment_replacer
    import ccr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_cmd,
    input  logic [7:0] i_in_char,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_char,
    output logic       o_char_valid,
    output logic       o_stream_end,
    output logic       o_last
);

    // input register
    logic       r_in_valid;
    logic       r_cmd;
    logic [7:0] r_char;

    t_scan_out  scan;
    t_result    res;
    logic       room;
    logic       adv;
    logic       push;
    logic       accept;

    // A scanned beat moves on when it yields nothing, or when the queue
    // will be empty to receive its results.
    assign adv    = r_in_valid && ((scan.count == 2'd0) || room);
    assign push   = adv && (scan.count != 2'd0);
    assign o_stall = r_in_valid && !adv;
    assign accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    // hold the payload until a new beat is taken
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_cmd;
            r_char <= i_in_char;
        end
    end

    ccr_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_cmd     (r_cmd),
        .i_in_char (r_char),
        .o_scan    (scan)
    );

    ccr_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_scan  (scan),
        .i_stall (i_stall),
        .o_room  (room),
        .o_valid (o_valid),
        .o_res   (res)
    );

    assign o_out_char   = res.out_char;
    assign o_char_valid = res.char_valid;
    assign o_stream_end = res.stream_end;
    assign o_last       = res.last;

endmodule

// ===== tb/sv/tb_c_comment_replacer.sv =====
`timescale 1ns / 1ps

module tb_c_comment_replacer;
    import ccr_pkg::*;

    // Traffic shapes, stepped through by the stimulus sequence
    typedef enum logic [2:0] {
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH,
        PH_PRESSURE
    } t_phase;

    typedef struct {
        logic       cmd;
        logic [7:0] ch;
    } t_beat;

    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam int HOLD_CYCLES  = 150;  // receiver hold-off in the pressure phase
    localparam int DRAIN_CYCLES = 16;   // quiet cycles after the last result
    localparam int MAX_REPORTS  = 100;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic       i_cmd        = CMD_CHAR;
    logic [7:0] i_in_char    = 8'h00;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_char;
    logic       o_char_valid;
    logic       o_stream_end;
    logic       o_last;

    t_phase     phase        = PH_FREE;
    t_phase     rx_phase     = PH_FREE;
    int         hold_left    = 0;
    logic       beat_taken   = 1'b0;

    t_beat      send_q[$];          // character beats waiting for the driver
    t_result    exp_results[$];     // results the scanner must still produce
    logic [2:0] scan_mode    = MODE_NORMAL;

    int         n_in         = 0;
    int         n_out        = 0;
    int         n_ends       = 0;
    int         n_errors     = 0;

    c_comment_replacer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_in_char    (i_in_char),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_char   (o_out_char),
        .o_char_valid (o_char_valid),
        .o_stream_end (o_stream_end),
        .o_last       (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Comment scanner prediction
    // ------------------------------------------------------------------

    function automatic t_result make_result(logic [7:0] c, logic v, logic e);
        t_result r;
        r.out_char   = c;
        r.char_valid = v;
        r.stream_end = e;
        r.last       = 1'b0;
        return r;
    endfunction

    // Advance the scanner by one accepted beat and queue what it must emit.
    task automatic scan_beat(input logic cmd, input logic [7:0] ch);
        t_result res [2];
        int      n;
        n = 0;
        if (cmd == CMD_END) begin
            // Flush a held slash, then close the stream; an open comment is dropped
            if (scan_mode == MODE_SLASH) begin
                res[n] = make_result(CH_SLASH, 1'b1, 1'b0);
                n++;
            end
            res[n] = make_result(8'h00, 1'b0, 1'b1);
            n++;
            scan_mode = MODE_NORMAL;
        end else begin
            case (scan_mode)
                MODE_SLASH: begin
                    if (ch == CH_SLASH || ch == CH_STAR) begin
                        // Opener complete: the whole comment becomes one space
                        res[n] = make_result(CH_SPACE, 1'b1, 1'b0);
                        n++;
                        scan_mode = (ch == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
                    end else begin
                        // Not an opener: release the slash, then pass the char
                        res[n] = make_result(CH_SLASH, 1'b1, 1'b0);
                        n++;
                        res[n] = make_result(ch, 1'b1, 1'b0);
                        n++;
                        scan_mode = MODE_NORMAL;
                    end
                end
                MODE_LINE: begin
                    // The terminating newline survives
                    if (ch == CH_NEWLINE) begin
                        res[n] = make_result(ch, 1'b1, 1'b0);
                        n++;
                        scan_mode = MODE_NORMAL;
                    end
                end
                MODE_BLOCK: begin
                    if (ch == CH_STAR)
                        scan_mode = MODE_STAR;
                end
                MODE_STAR: begin
                    // Star runs stay here, a slash closes, anything else falls back
                    if (ch == CH_SLASH)
                        scan_mode = MODE_NORMAL;
                    else if (ch != CH_STAR)
                        scan_mode = MODE_BLOCK;
                end
                default: begin
                    if (ch == CH_SLASH) begin
                        scan_mode = MODE_SLASH;
                    end else begin
                        res[n] = make_result(ch, 1'b1, 1'b0);
                        n++;
                        scan_mode = MODE_NORMAL;
                    end
                end
            endcase
        end
        if (n > 0)
            res[n - 1].last = 1'b1;
        for (int k = 0; k < n; k++)
            exp_results.push_back(res[k]);
    endtask

    task automatic report(input string msg);
        if (n_errors < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report($sformatf("%s got %02h want %02h (result %0d)", name, got, want, n_out));
    endtask

    // ------------------------------------------------------------------
    // Driver: present queued beats at the falling edge
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        t_beat b;
        bit    idle;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || beat_taken) begin
            // Previous beat gone (or none held): offer the next one or go idle
            case (phase)
                PH_SEND_IDLE: idle = ($urandom_range(99) < 68);
                PH_BOTH:      idle = ($urandom_range(99) < 30);
                default:      idle = 1'b0;
            endcase
            if (send_q.size() != 0 && !idle) begin
                b = send_q.pop_front();
                i_cmd     <= b.cmd;
                i_in_char <= b.ch;
                i_valid   <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
        // else hold: the stalled beat stays on the bus unchanged
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern per phase, with one long hold-off
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (phase != rx_phase) begin
            // Entering a new phase; the pressure phase opens with a long hold
            rx_phase  <= phase;
            hold_left <= (phase == PH_PRESSURE) ? HOLD_CYCLES : 0;
            i_stall   <= (phase == PH_PRESSURE);
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            case (phase)
                PH_RECV_STALL: i_stall <= ($urandom_range(99) < 68);
                PH_BOTH:       i_stall <= ($urandom_range(99) < 30);
                PH_PRESSURE:   i_stall <= ($urandom_range(99) < 20);
                default:       i_stall <= 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on accepted input beats, check accepted results.
    // Predict first so a result in the same edge finds its expectation.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_result want;
        beat_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            scan_beat(i_cmd, i_in_char);
            n_in++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (exp_results.size() == 0) begin
                report($sformatf("unexpected result char %02h valid %b end %b last %b",
                                 o_out_char, o_char_valid, o_stream_end, o_last));
            end else begin
                want = exp_results.pop_front();
                check_field("out_char",   o_out_char,   want.out_char);
                check_field("char_valid", {7'd0, o_char_valid}, {7'd0, want.char_valid});
                check_field("stream_end", {7'd0, o_stream_end}, {7'd0, want.stream_end});
                check_field("last",       {7'd0, o_last},       {7'd0, want.last});
                if (want.stream_end)
                    n_ends++;
            end
            n_out++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic push_char(input logic [7:0] ch);
        t_beat b;
        b.cmd = CMD_CHAR;
        b.ch  = ch;
        send_q.push_back(b);
    endtask

    task automatic push_end(input logic [7:0] junk);
        t_beat b;
        b.cmd = CMD_END;
        b.ch  = junk;
        send_q.push_back(b);
    endtask

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(255));
    endfunction

    // One source-like stream: text, line and block comments, stray slashes
    // and stars, usually closed by an end beat.
    task automatic gen_stream();
        int pieces;
        int m;
        pieces = $urandom_range(20, 1);
        for (int k = 0; k < pieces; k++) begin
            case ($urandom_range(10))
                0, 1, 2, 3: begin
                    if ($urandom_range(4) != 0)
                        push_char(8'($urandom_range(126, 32)));
                    else
                        push_char(any_byte());
                end
                4: begin
                    push_char(CH_SLASH);
                    push_char(CH_SLASH);
                    m = $urandom_range(8);
                    repeat (m) push_char(any_byte());
                    push_char(CH_NEWLINE);
                end
                5: begin
                    push_char(CH_SLASH);
                    push_char(CH_STAR);
                    m = $urandom_range(8);
                    repeat (m) begin
                        case ($urandom_range(3))
                            0:       push_char(CH_STAR);
                            1:       push_char(CH_SLASH);
                            default: push_char(any_byte());
                        endcase
                    end
                    m = $urandom_range(3, 1);
                    repeat (m) push_char(CH_STAR);
                    push_char(CH_SLASH);
                end
                6: begin
                    push_char(CH_SLASH);
                    push_char(any_byte());
                end
                7: push_char(CH_NEWLINE);
                8: push_char(CH_STAR);
                9: begin
                    m = $urandom_range(3, 1);
                    repeat (m) push_char(CH_SLASH);
                end
                default: begin
                    // Leave a comment open and cut the stream short
                    push_char(CH_SLASH);
                    push_char($urandom_range(1) ? CH_STAR : CH_SLASH);
                    m = $urandom_range(3);
                    repeat (m) push_char(any_byte());
                    break;
                end
            endcase
        end
        if ($urandom_range(9) != 0)
            push_end(any_byte());
    endtask

    task automatic gen_noise();
        int m;
        m = $urandom_range(12, 1);
        repeat (m) begin
            if ($urandom_range(9) == 0)
                push_end(any_byte());
            else
                push_char(any_byte());
        end
    endtask

    task automatic fill(input int target);
        int n0;
        n0 = send_q.size();
        while (send_q.size() - n0 < target) begin
            if ($urandom_range(6) == 0)
                gen_noise();
            else
                gen_stream();
        end
    endtask

    // Block until the driver has handed over every queued beat.
    task automatic wait_sent();
        while (send_q.size() != 0 || i_valid)
            @(posedge i_clk);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: byte extremes, slash release, line comment with its
        // newline, slash-star-slash staying inside, star runs, closing,
        // end of stream with a held slash, inside a comment and in plain text.
        phase = PH_FREE;
        push_char(8'h61);
        push_char(8'h00);
        push_char(8'hFF);
        push_char(CH_SLASH);
        push_char(8'h78);
        push_char(CH_SLASH);
        push_char(CH_SLASH);
        push_char(8'h7A);
        push_char(CH_NEWLINE);
        push_char(CH_SLASH);
        push_char(CH_STAR);
        push_char(CH_SLASH);
        push_char(CH_STAR);
        push_char(CH_STAR);
        push_char(8'h71);
        push_char(CH_STAR);
        push_char(CH_SLASH);
        push_char(CH_SLASH);
        push_end(8'hA5);
        push_char(CH_SLASH);
        push_char(CH_STAR);
        push_char(8'h6B);
        push_end(8'h5A);
        push_end(8'hFF);
        wait_sent();

        // Random streams under each traffic shape
        fill(400);
        wait_sent();

        phase = PH_SEND_IDLE;
        fill(350);
        wait_sent();

        phase = PH_RECV_STALL;
        fill(350);
        wait_sent();

        phase = PH_BOTH;
        fill(400);
        wait_sent();

        // Fill first so the sender keeps offering through the hold-off
        fill(300);
        phase = PH_PRESSURE;
        wait_sent();

        // Drain with the receiver open, then watch for stray results
        phase = PH_FREE;
        while (exp_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d input beats and %0d results, %0d streams closed,",
                 n_in, n_out, n_ends);
        $display("under free flow, sender gaps, receiver stalls, both, and a long hold-off.");
        if (n_errors == 0 && exp_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog: a hung handshake ends here
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
